@@ hdl/b2da_pkg.sv @@
package b2da_pkg;

  localparam int VALUE_W            = 31;
  localparam int CHAR_W             = 6;
  localparam int DEFAULT_MAX_DIGITS = 10;
  localparam int STEP_W             = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift_bin;
    logic shift_dig;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic more_digits;
    logic overflow;
  } status_t;

endpackage

@@ hdl/b2da_ctrl.sv @@
module b2da_ctrl
  import b2da_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift_bin = 1'b1;
        if (status.conv_done) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep the last digit and all digits after a wrap
        if (status.top_zero && status.more_digits && !status.overflow) begin
          cmd.shift_dig = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.more_digits) begin
            cmd.shift_dig = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/b2da_dp.sv @@
module b2da_dp
  import b2da_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic              clk,
  input  cmd_t              cmd,
  input  logic [VALUE_W-1:0] value,
  output status_t           status,
  output logic [CHAR_W-1:0] digit_char,
  output logic              last
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int REM_W = $clog2(MAX_DIGITS + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);
  localparam logic [REM_W-1:0]  REM_FULL  = REM_W'(MAX_DIGITS);
  localparam logic [REM_W-1:0]  REM_ONE   = REM_W'(1);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [STEP_W-1:0]  step;
  logic [REM_W-1:0]   remaining;
  logic               overflow;
  logic [3:0]         top;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin       <= value;
      bcd       <= '0;
      step      <= '0;
      overflow  <= 1'b0;
      remaining <= REM_FULL;
    end else if (cmd.shift_bin) begin
      bcd      <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin      <= bin << 1;
      // a bit carried out of the top digit means the value wraps
      overflow <= overflow | bcd_adj[BCD_W-1];
      step     <= step + STEP_W'(1);
    end else if (cmd.shift_dig) begin
      bcd       <= bcd << 4;
      remaining <= remaining - REM_ONE;
    end
  end

  assign top = bcd[BCD_W-1 -: 4];

  assign status.conv_done   = (step == LAST_STEP);
  assign status.top_zero    = (top == 4'd0);
  assign status.more_digits = (remaining > REM_ONE);
  assign status.overflow    = overflow;

  assign digit_char = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top};
  assign last       = (remaining == REM_ONE);

endmodule

@@ hdl/binary_to_decimal_ascii_top.sv @@
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata[30:0] value
// m        out  m_tvalid/m_tready  m_tdata[5:0] digit_char, m_tlast last
//
// One value at a time: load, shift-and-add-3 over all 31 value bits in the
// BCD register, drop leading zeros, then one digit per cycle while
// m_tready is high.
// rst is synchronous and clears the controller only.
// A stall on m holds the current digit; s_tready stays low until the last
// digit is taken.
module binary_to_decimal_ascii_top
  import b2da_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] value, [31] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic        m_tlast
);

  cmd_t              cmd;
  status_t           status;
  logic [CHAR_W-1:0] digit_char;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  b2da_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .value      (s_tdata[VALUE_W-1:0]),
    .status     (status),
    .digit_char (digit_char),
    .last       (m_tlast)
  );

  assign m_tdata = {{(8-CHAR_W){1'b0}}, digit_char};

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted while a digit is pending");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:0] >= 6'd48) && (m_tdata[5:0] <= 6'd57))
    else $error("digit character out of range");

  a_load_no_out: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("digit shown before conversion");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not ready after last digit");

endmodule
